// File: design/pcp_pkg.sv
// Shared types, constants and helpers of the pendulum cascade balance controller.
// No dependencies; every other file of the block imports this package.
package pcp_pkg;

    localparam int ADC_BITS   = 12;
    localparam int DRIVE_BITS = 14;

    localparam int ENC_W      = 16;
    localparam int KEY_W      = 3;
    localparam int KP_W       = 8;
    localparam int KD_W       = 8;
    localparam int SKP_W      = 10;
    localparam int SKI_W      = 8;
    localparam int ILIM_W     = 15;
    localparam int LIM_W      = 13;
    localparam int TURN_W     = 13;

    localparam int ERR_W      = ADC_BITS + 1;
    localparam int DIFF_W     = ADC_BITS + 2;
    localparam int TERM_W     = LIM_W + 1;
    localparam int SUM_W      = TERM_W + 2;
    localparam int CLAMP_IN_W = 28;
    localparam int FILT_W     = 32;
    localparam int INTEG_W    = 32;
    localparam int SWING_W    = 7;

    localparam int MAC_W      = 50;
    localparam int MPY_W      = 16;
    localparam int FRAC_BITS  = 15;
    localparam int FLT_SHIFT  = 16;
    localparam int SPEED_ALIGN = 8;
    localparam int SP_SHIFT   = FRAC_BITS + SPEED_ALIGN;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int IN_DATA_W  = ((ADC_BITS + ENC_W + 7) / 8) * 8;
    localparam int IN_USER_W  = 1 + KEY_W;
    localparam int OUT_DATA_W = ((2 * DRIVE_BITS + 7) / 8) * 8;

    localparam logic [ADC_BITS-1:0]   WIN_LOW    = ADC_BITS'(400);
    localparam logic [ADC_BITS-1:0]   WIN_HIGH   = ADC_BITS'(1700);
    localparam logic [DRIVE_BITS-1:0] DRIVE_MAX  = '1;
    localparam logic [DRIVE_BITS-1:0] SWING_DUTY = DRIVE_BITS'(2000);
    localparam logic [SWING_W-1:0]    SWING_HALF = SWING_W'(59);
    localparam logic [SWING_W-1:0]    SWING_END  = SWING_W'(119);
    localparam logic [MPY_W-1:0]      NEW_WEIGHT = MPY_W'(19661);
    localparam logic [MPY_W-1:0]      OLD_WEIGHT = MPY_W'(45875);
    localparam logic [MAC_W-1:0]      ROUND_HALF = MAC_W'(1) << (FLT_SHIFT - 1);
    localparam logic [MAC_W-1:0]      SP_BIAS    = (MAC_W'(1) << SP_SHIFT) - MAC_W'(1);

    localparam logic [KEY_W-1:0] KEY_SWING     = KEY_W'(1);
    localparam logic [KEY_W-1:0] KEY_BAL_LO    = KEY_W'(3);
    localparam logic [KEY_W-1:0] KEY_SWING_OUT = KEY_W'(4);
    localparam logic [KEY_W-1:0] KEY_TURN      = KEY_W'(6);
    localparam logic [KEY_W-1:0] KEY_BAL_HI    = KEY_W'(6);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_ANGLE   = 3'd0,
        CFG_UPRIGHT_KP     = 3'd1,
        CFG_UPRIGHT_KD     = 3'd2,
        CFG_SPEED_KP       = 3'd3,
        CFG_SPEED_KI       = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5,
        CFG_DRIVE_LIMIT    = 3'd6,
        CFG_TURN_OFFSET    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [ADC_BITS-1:0]      target_angle;
        logic [KP_W-1:0]          upright_kp;
        logic [KD_W-1:0]          upright_kd;
        logic [SKP_W-1:0]         speed_kp;
        logic [SKI_W-1:0]         speed_ki;
        logic [ILIM_W-1:0]        integral_limit;
        logic [LIM_W-1:0]         drive_limit;
        logic signed [TURN_W-1:0] turn_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        target_angle:   ADC_BITS'(1050),
        upright_kp:     KP_W'(14),
        upright_kd:     KD_W'(35),
        speed_kp:       SKP_W'(336),
        speed_ki:       SKI_W'(77),
        integral_limit: ILIM_W'(1000),
        drive_limit:    LIM_W'(7000),
        turn_offset:    TURN_W'(1000)
    };

    typedef struct packed {
        logic [DRIVE_BITS-1:0] fw;
        logic [DRIVE_BITS-1:0] rv;
        logic                  bal;
    } res_t;

    typedef struct packed {
        logic start;
        logic clear;
    } mac_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_LOAD,
        ST_MUL_RUN,
        ST_UP_CLAMP,
        ST_FLT_ROUND,
        ST_INTEG,
        ST_SP_CLAMP,
        ST_SUM,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_UP_KP,
        OP_UP_KD,
        OP_FLT_NEW,
        OP_FLT_OLD,
        OP_SP_KP,
        OP_SP_KI
    } mul_op_t;

    function automatic logic signed [TERM_W-1:0] clamp_term(
        input logic signed [CLAMP_IN_W-1:0] x,
        input logic [LIM_W-1:0]             lim
    );
        logic signed [CLAMP_IN_W-1:0] l;
        logic signed [CLAMP_IN_W-1:0] r;
        l = $signed(CLAMP_IN_W'(lim));
        if (x > l)
        begin
            r = l;
        end
        else if (x < -l)
        begin
            r = -l;
        end
        else
        begin
            r = x;
        end
        return TERM_W'(r);
    endfunction

endpackage

// File: design/pendulum_cascade_pid.sv
// Top level of the pendulum cascade balance controller: config registers, output register.
// Depends on pcp_pkg, pcp_mac and pcp_ctrl.
//
// One input beat is one control tick and yields exactly one output beat. A balance tick runs
// up to six products through one serial shift-add multiplier that retires one multiplier bit
// per cycle and stops at the highest set bit of the gain: upright kp and kd (8 bits each), the
// two speed filter weights (15 and 16 bits), speed kp (10 bits) and ki (8 bits), so small
// gains finish sooner; an input outside the angle window with a balance key runs only the two
// speed filter products. One tick is worked on at a time; a finished result sits in the
// output register so the next tick can be accepted while it waits.
module pendulum_cascade_pid (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // angle_sample [11:0], encoder_count [27:12], zero fill above
    input  logic [pcp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // run_enable [0], mode_key [3:1]
    input  logic [pcp_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // drive_forward [13:0], drive_reverse [27:14], zero fill above
    output logic [pcp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // balancing [0]
    output logic                              m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pcp_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    logic                    res_valid;
    logic                    res_ready;
    res_t                    res;
    mac_ctl_t                mac_ctl;
    logic signed [MAC_W-1:0] mac_mcand;
    logic [MPY_W-1:0]        mac_mplier;
    logic                    mac_busy;
    logic signed [MAC_W-1:0] mac_acc;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_TARGET_ANGLE:   cfg_next.target_angle   = cfg_data[ADC_BITS-1:0];
                CFG_UPRIGHT_KP:     cfg_next.upright_kp     = cfg_data[KP_W-1:0];
                CFG_UPRIGHT_KD:     cfg_next.upright_kd     = cfg_data[KD_W-1:0];
                CFG_SPEED_KP:       cfg_next.speed_kp       = cfg_data[SKP_W-1:0];
                CFG_SPEED_KI:       cfg_next.speed_ki       = cfg_data[SKI_W-1:0];
                CFG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[ILIM_W-1:0];
                CFG_DRIVE_LIMIT:    cfg_next.drive_limit    = cfg_data[LIM_W-1:0];
                CFG_TURN_OFFSET:    cfg_next.turn_offset    = $signed(cfg_data[TURN_W-1:0]);
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'({out_res_reg.rv, out_res_reg.fw});
    assign m_axis_tuser  = out_res_reg.bal;

    pcp_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .mcand  (mac_mcand),
        .mplier (mac_mplier),
        .busy   (mac_busy),
        .acc    (mac_acc)
    );

    pcp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_angle   (s_axis_tdata[ADC_BITS-1:0]),
        .in_encoder (s_axis_tdata[ADC_BITS +: ENC_W]),
        .in_run     (s_axis_tuser[0]),
        .in_key     (s_axis_tuser[1 +: KEY_W]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mac_ctl    (mac_ctl),
        .mac_mcand  (mac_mcand),
        .mac_mplier (mac_mplier),
        .mac_busy   (mac_busy),
        .mac_acc    (mac_acc)
    );

endmodule

// File: design/pcp_mac.sv
// Serial shift-add multiply-accumulate unit: one multiplier bit per cycle.
// Depends on pcp_pkg for widths and the control struct.
module pcp_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pcp_pkg::mac_ctl_t                ctl,
    input  logic signed [pcp_pkg::MAC_W-1:0] mcand,
    input  logic [pcp_pkg::MPY_W-1:0]        mplier,
    output logic                             busy,
    output logic signed [pcp_pkg::MAC_W-1:0] acc
);
    import pcp_pkg::*;

    logic [MPY_W-1:0]        mplier_reg, mplier_next;
    logic signed [MAC_W-1:0] mcand_reg, mcand_next;
    logic signed [MAC_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        acc_next    = acc_reg;
        if (ctl.start)
        begin
            mplier_next = mplier;
            mcand_next  = mcand;
            if (ctl.clear)
            begin
                acc_next = '0;
            end
        end
        else if (mplier_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mplier_reg <= '0;
        end
        else
        begin
            mplier_reg <= mplier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
    end

    assign busy = (mplier_reg != '0);
    assign acc  = acc_reg;

endmodule

// File: design/pcp_ctrl.sv
// Control sequencer and loop state of the balance controller.
// Depends on pcp_pkg; drives the serial multiplier pcp_mac through its operand ports.
module pcp_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pcp_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [pcp_pkg::ADC_BITS-1:0]        in_angle,
    input  logic [pcp_pkg::ENC_W-1:0]           in_encoder,
    input  logic                                in_run,
    input  logic [pcp_pkg::KEY_W-1:0]           in_key,
    output logic                                res_valid,
    input  logic                                res_ready,
    output pcp_pkg::res_t                       res,
    output pcp_pkg::mac_ctl_t                   mac_ctl,
    output logic signed [pcp_pkg::MAC_W-1:0]    mac_mcand,
    output logic [pcp_pkg::MPY_W-1:0]           mac_mplier,
    input  logic                                mac_busy,
    input  logic signed [pcp_pkg::MAC_W-1:0]    mac_acc
);
    import pcp_pkg::*;

    state_t  state_reg, state_next;
    mul_op_t op_reg, op_next;

    logic [ADC_BITS-1:0]      angle_reg, angle_next;
    logic [ENC_W-1:0]         enc_reg, enc_next;
    logic                     run_reg, run_next;
    logic [KEY_W-1:0]         key_reg, key_next;

    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [ERR_W-1:0]   prev_err_reg, prev_err_next;
    logic signed [FILT_W-1:0]  filt_reg, filt_next;
    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic [SWING_W-1:0]        swing_reg, swing_next;
    logic [DRIVE_BITS-1:0]     held_fw_reg, held_fw_next;
    logic [DRIVE_BITS-1:0]     held_rv_reg, held_rv_next;
    logic signed [TERM_W-1:0]  up_reg, up_next;
    logic signed [TERM_W-1:0]  sp_reg, sp_next;
    res_t                      res_reg, res_next;

    logic                        in_win;
    logic                        bal_key;
    logic signed [ERR_W-1:0]     err_now;
    logic signed [DIFF_W-1:0]    diff_now;
    logic signed [ENC_W:0]       spd;
    logic [DRIVE_BITS-1:0]       swing_fw;
    logic [DRIVE_BITS-1:0]       swing_rv;
    logic [SWING_W-1:0]          swing_adv;
    logic signed [MAC_W-1:0]     flt_round;
    logic signed [INTEG_W:0]     isum;
    logic signed [INTEG_W:0]     ilim;
    logic signed [INTEG_W-1:0]   integ_new;
    logic signed [MAC_W-1:0]     sp_add;
    logic signed [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]            sum_mag;
    logic [DRIVE_BITS-1:0]       sum_sat;

    // shared arithmetic
    always_comb
    begin
        in_win   = (angle_reg > WIN_LOW) && (angle_reg < WIN_HIGH);
        bal_key  = (key_reg >= KEY_BAL_LO) && (key_reg <= KEY_BAL_HI);
        err_now  = $signed({1'b0, cfg.target_angle}) - $signed({1'b0, angle_reg});
        diff_now = DIFF_W'(err_now) - DIFF_W'(prev_err_reg);
        spd      = -$signed({enc_reg[ENC_W-1], enc_reg});

        if (swing_reg < SWING_HALF)
        begin
            swing_fw = SWING_DUTY;
            swing_rv = '0;
        end
        else
        begin
            swing_fw = '0;
            swing_rv = SWING_DUTY;
        end
        swing_adv = (swing_reg > SWING_END) ? SWING_W'(1) : swing_reg + SWING_W'(1);

        flt_round = mac_acc + $signed(ROUND_HALF);

        isum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(filt_reg);
        ilim = $signed((INTEG_W+1)'({cfg.integral_limit, FRAC_BITS'(0)}));
        if (isum > ilim)
        begin
            integ_new = INTEG_W'(ilim);
        end
        else if (isum < -ilim)
        begin
            integ_new = INTEG_W'(-ilim);
        end
        else
        begin
            integ_new = INTEG_W'(isum);
        end

        // truncation toward zero: bias negative values before the shift
        sp_add = mac_acc + (mac_acc[MAC_W-1] ? $signed(SP_BIAS) : $signed(MAC_W'(0)));

        sum = SUM_W'(up_reg) + SUM_W'(sp_reg)
            + ((key_reg == KEY_TURN) ? SUM_W'($signed(cfg.turn_offset)) : SUM_W'(0));
        sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        sum_sat = (sum_mag > SUM_W'(DRIVE_MAX)) ? DRIVE_MAX : sum_mag[DRIVE_BITS-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (run_reg && bal_key)
                begin
                    state_next = ST_MUL_LOAD;
                    op_next    = in_win ? OP_UP_KP : OP_FLT_NEW;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_LOAD:
            begin
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                if (!mac_busy)
                begin
                    unique case (op_reg)
                        OP_UP_KP:
                        begin
                            op_next    = OP_UP_KD;
                            state_next = ST_MUL_LOAD;
                        end
                        OP_UP_KD:   state_next = ST_UP_CLAMP;
                        OP_FLT_NEW:
                        begin
                            op_next    = OP_FLT_OLD;
                            state_next = ST_MUL_LOAD;
                        end
                        OP_FLT_OLD: state_next = ST_FLT_ROUND;
                        OP_SP_KP:
                        begin
                            op_next    = OP_SP_KI;
                            state_next = ST_MUL_LOAD;
                        end
                        OP_SP_KI:   state_next = ST_SP_CLAMP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UP_CLAMP:
            begin
                op_next    = OP_FLT_NEW;
                state_next = ST_MUL_LOAD;
            end
            ST_FLT_ROUND:
            begin
                state_next = in_win ? ST_INTEG : ST_FINISH;
            end
            ST_INTEG:
            begin
                op_next    = OP_SP_KP;
                state_next = ST_MUL_LOAD;
            end
            ST_SP_CLAMP: state_next = ST_SUM;
            ST_SUM:      state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        res_valid     = (state_reg == ST_FINISH);
        res           = res_reg;
        mac_ctl.start = (state_reg == ST_MUL_LOAD);
        mac_ctl.clear = 1'b0;
        unique case (op_reg)
            OP_UP_KP:
            begin
                mac_mcand     = MAC_W'(err_reg);
                mac_mplier    = MPY_W'(cfg.upright_kp);
                mac_ctl.clear = 1'b1;
            end
            OP_UP_KD:
            begin
                mac_mcand  = MAC_W'(diff_reg);
                mac_mplier = MPY_W'(cfg.upright_kd);
            end
            OP_FLT_NEW:
            begin
                mac_mcand     = MAC_W'(spd) <<< FRAC_BITS;
                mac_mplier    = NEW_WEIGHT;
                mac_ctl.clear = 1'b1;
            end
            OP_FLT_OLD:
            begin
                mac_mcand  = MAC_W'(filt_reg);
                mac_mplier = OLD_WEIGHT;
            end
            OP_SP_KP:
            begin
                mac_mcand     = MAC_W'(filt_reg) <<< SPEED_ALIGN;
                mac_mplier    = MPY_W'(cfg.speed_kp);
                mac_ctl.clear = 1'b1;
            end
            OP_SP_KI:
            begin
                mac_mcand  = MAC_W'(integ_reg);
                mac_mplier = MPY_W'(cfg.speed_ki);
            end
            default:
            begin
                mac_mcand  = '0;
                mac_mplier = '0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        angle_next    = angle_reg;
        enc_next      = enc_reg;
        run_next      = run_reg;
        key_next      = key_reg;
        err_next      = err_reg;
        diff_next     = diff_reg;
        prev_err_next = prev_err_reg;
        filt_next     = filt_reg;
        integ_next    = integ_reg;
        swing_next    = swing_reg;
        held_fw_next  = held_fw_reg;
        held_rv_next  = held_rv_reg;
        up_next       = up_reg;
        sp_next       = sp_reg;
        res_next      = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    angle_next = in_angle;
                    enc_next   = in_encoder;
                    run_next   = in_run;
                    key_next   = in_key;
                end
            end
            ST_DECODE:
            begin
                priority if (!run_reg)
                begin
                    res_next     = '0;
                    held_fw_next = '0;
                    held_rv_next = '0;
                end
                else if (key_reg == KEY_SWING)
                begin
                    res_next     = '{fw: swing_fw, rv: swing_rv, bal: 1'b0};
                    held_fw_next = swing_fw;
                    held_rv_next = swing_rv;
                    swing_next   = swing_adv;
                end
                else if (bal_key)
                begin
                    if (in_win)
                    begin
                        err_next      = err_now;
                        diff_next     = diff_now;
                        prev_err_next = err_now;
                    end
                end
                else
                begin
                    res_next = '{fw: held_fw_reg, rv: held_rv_reg, bal: 1'b0};
                end
            end
            ST_UP_CLAMP:
            begin
                up_next = clamp_term($signed(mac_acc[CLAMP_IN_W-1:0]), cfg.drive_limit);
            end
            ST_FLT_ROUND:
            begin
                filt_next = flt_round[FILT_W+FLT_SHIFT-1:FLT_SHIFT];
                if (!in_win)
                begin
                    integ_next = '0;
                    if (key_reg == KEY_SWING_OUT)
                    begin
                        res_next     = '{fw: swing_fw, rv: swing_rv, bal: 1'b0};
                        held_fw_next = swing_fw;
                        held_rv_next = swing_rv;
                        swing_next   = swing_adv;
                    end
                    else
                    begin
                        res_next     = '0;
                        held_fw_next = '0;
                        held_rv_next = '0;
                    end
                end
            end
            ST_INTEG:
            begin
                integ_next = integ_new;
            end
            ST_SP_CLAMP:
            begin
                sp_next = clamp_term(CLAMP_IN_W'($signed(sp_add[MAC_W-1:SP_SHIFT])),
                                     cfg.drive_limit);
            end
            ST_SUM:
            begin
                if (sum[SUM_W-1])
                begin
                    res_next     = '{fw: sum_sat, rv: '0, bal: 1'b1};
                    held_fw_next = sum_sat;
                    held_rv_next = '0;
                end
                else
                begin
                    res_next     = '{fw: '0, rv: sum_sat, bal: 1'b1};
                    held_fw_next = '0;
                    held_rv_next = sum_sat;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_UP_KP;
            err_reg      <= '0;
            diff_reg     <= '0;
            prev_err_reg <= '0;
            filt_reg     <= '0;
            integ_reg    <= '0;
            swing_reg    <= '0;
            held_fw_reg  <= '0;
            held_rv_reg  <= '0;
            up_reg       <= '0;
            sp_reg       <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            err_reg      <= err_next;
            diff_reg     <= diff_next;
            prev_err_reg <= prev_err_next;
            filt_reg     <= filt_next;
            integ_reg    <= integ_next;
            swing_reg    <= swing_next;
            held_fw_reg  <= held_fw_next;
            held_rv_reg  <= held_rv_next;
            up_reg       <= up_next;
            sp_reg       <= sp_next;
            res_reg      <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        enc_reg   <= enc_next;
        run_reg   <= run_next;
        key_reg   <= key_next;
    end

    a_idle_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mac_busy)
        else $error("multiplier still running while idle");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted beat not decoded next cycle");

    a_swing_range: assert property (@(posedge clk) disable iff (!rst_n)
        swing_reg <= SWING_END + SWING_W'(1))
        else $error("swing phase out of range");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        !((res_reg.fw != '0) && (res_reg.rv != '0)))
        else $error("both drive directions active");

endmodule

// File: dv/pendulum_cascade_pid_test.sv
// Self-checking testbench for pendulum_cascade_pid: a queue-fed stream driver, a result
// monitor and an in-bench predictor of the cascaded PD/PI balance loop.
// Depends on pcp_pkg and the pendulum_cascade_pid RTL.
module pendulum_cascade_pid_test;
    import pcp_pkg::*;

    localparam logic [KEY_W-1:0] KEY_HOLD0   = KEY_W'(0);
    localparam logic [KEY_W-1:0] KEY_HOLD2   = KEY_W'(2);
    localparam logic [KEY_W-1:0] KEY_BAL_MID = KEY_W'(5);
    localparam logic [KEY_W-1:0] KEY_HOLD7   = KEY_W'(7);

    typedef struct packed {
        logic [ADC_BITS-1:0] angle;
        logic [ENC_W-1:0]    enc;
        logic                run;
        logic [KEY_W-1:0]    key;
    } tick_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pendulum_cascade_pid uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor state
    cfg_t                 pid_cfg;
    int                   pid_prev_err;
    int                   pid_filt;
    int                   pid_integ;
    logic [SWING_W-1:0]   pid_swing;
    logic [DRIVE_BITS-1:0] pid_held_fw;
    logic [DRIVE_BITS-1:0] pid_held_rv;

    tick_t tick_q[$];
    res_t  drive_exp_q[$];
    tick_t cur_tick;
    res_t  want;

    int idle_pct;
    int errors;
    int ticks_loaded;
    int ticks_taken;
    int results_seen;
    int balance_ticks;
    int saturated_ticks;
    int settings_used;

    always #5 clk = ~clk;

    function automatic longint clamp_mag(longint x, longint lim);
        if (x > lim)
        begin
            return lim;
        end
        if (x < -lim)
        begin
            return -lim;
        end
        return x;
    endfunction

    function automatic void filter_speed(logic [ENC_W-1:0] cnt);
        longint s;
        longint acc;
        s = -longint'($signed(cnt));
        acc = s * (longint'(1) << FRAC_BITS) * longint'(NEW_WEIGHT)
            + longint'(pid_filt) * longint'(OLD_WEIGHT);
        pid_filt = int'((acc + (longint'(1) << (FLT_SHIFT - 1))) >>> FLT_SHIFT);
    endfunction

    function automatic void swing_step(inout res_t r);
        if (pid_swing < SWING_HALF)
        begin
            r.fw = SWING_DUTY;
            r.rv = '0;
        end
        else
        begin
            r.fw = '0;
            r.rv = SWING_DUTY;
        end
        if (pid_swing > SWING_END)
        begin
            pid_swing = '0;
        end
        pid_swing = pid_swing + 1'b1;
    endfunction

    function automatic res_t predict_drive(tick_t t);
        res_t   r;
        longint lim;
        longint err;
        longint up;
        longint integ;
        longint sp;
        longint sum;
        longint dmax;
        r = '0;
        dmax = longint'(DRIVE_MAX);
        if (!t.run)
        begin
            pid_held_fw = '0;
            pid_held_rv = '0;
        end
        else if (t.key == KEY_SWING)
        begin
            swing_step(r);
            pid_held_fw = r.fw;
            pid_held_rv = r.rv;
        end
        else if (t.key >= KEY_BAL_LO && t.key <= KEY_BAL_HI)
        begin
            if (t.angle > WIN_LOW && t.angle < WIN_HIGH)
            begin
                lim = longint'(pid_cfg.drive_limit);
                err = longint'(pid_cfg.target_angle) - longint'(t.angle);
                up = longint'(pid_cfg.upright_kp) * err
                   + longint'(pid_cfg.upright_kd) * (err - longint'(pid_prev_err));
                pid_prev_err = int'(err);
                up = clamp_mag(up, lim);
                filter_speed(t.enc);
                integ = clamp_mag(longint'(pid_integ) + longint'(pid_filt),
                                  longint'(pid_cfg.integral_limit) << FRAC_BITS);
                pid_integ = int'(integ);
                sp = longint'(pid_cfg.speed_kp) * longint'(pid_filt) * (longint'(1) << SPEED_ALIGN)
                   + longint'(pid_cfg.speed_ki) * integ;
                sp = (sp >= 0) ? (sp >>> SP_SHIFT) : -((-sp) >>> SP_SHIFT);
                sp = clamp_mag(sp, lim);
                sum = up + sp;
                if (t.key == KEY_TURN)
                begin
                    sum = sum + longint'($signed(pid_cfg.turn_offset));
                end
                if (sum > dmax || -sum > dmax)
                begin
                    saturated_ticks++;
                end
                if (sum < 0)
                begin
                    r.fw = DRIVE_BITS'((-sum > dmax) ? dmax : -sum);
                end
                else
                begin
                    r.rv = DRIVE_BITS'((sum > dmax) ? dmax : sum);
                end
                r.bal = 1'b1;
                balance_ticks++;
            end
            else
            begin
                filter_speed(t.enc);
                pid_integ = 0;
                if (t.key == KEY_SWING_OUT)
                begin
                    swing_step(r);
                end
            end
            pid_held_fw = r.fw;
            pid_held_rv = r.rv;
        end
        else
        begin
            r.fw = pid_held_fw;
            r.rv = pid_held_rv;
        end
        return r;
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        int    r;
        t = '0;
        r = $urandom_range(99);
        if (r < 12)
        begin
            t.angle = ADC_BITS'($urandom);
            t.enc   = ENC_W'($urandom);
            t.run   = 1'($urandom);
            t.key   = KEY_W'($urandom);
            return t;
        end
        t.run = ($urandom_range(49) != 0);
        r = $urandom_range(99);
        if (r < 8)
        begin
            t.key = KEY_SWING;
        end
        else if (r < 12)
        begin
            case ($urandom_range(2))
                0: t.key = KEY_HOLD0;
                1: t.key = KEY_HOLD2;
                default: t.key = KEY_HOLD7;
            endcase
        end
        else
        begin
            t.key = KEY_W'($urandom_range(KEY_BAL_HI, KEY_BAL_LO));
        end
        r = $urandom_range(99);
        if (r < 80)
        begin
            t.angle = ADC_BITS'($urandom_range(WIN_HIGH - 1, WIN_LOW + 1));
        end
        else if (r < 90)
        begin
            t.angle = ADC_BITS'($urandom_range(WIN_LOW));
        end
        else
        begin
            t.angle = ADC_BITS'($urandom_range((1 << ADC_BITS) - 1, WIN_HIGH));
        end
        if ($urandom_range(99) < 85)
        begin
            t.enc = ENC_W'($urandom_range(400) - 200);
        end
        else
        begin
            t.enc = ENC_W'($urandom);
        end
        return t;
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        if ($urandom_range(3) == 0)
        begin
            c.target_angle = ADC_BITS'($urandom);
        end
        else
        begin
            c.target_angle = ADC_BITS'($urandom_range(1500, 600));
        end
        c.upright_kp     = KP_W'($urandom);
        c.upright_kd     = KD_W'($urandom);
        c.speed_kp       = SKP_W'($urandom);
        c.speed_ki       = SKI_W'($urandom);
        c.integral_limit = ILIM_W'($urandom);
        c.drive_limit    = LIM_W'($urandom_range(7200));
        c.turn_offset    = TURN_W'($urandom);
        return c;
    endfunction

    function automatic void check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TARGET_ANGLE:   pid_cfg.target_angle   = val[ADC_BITS-1:0];
            CFG_UPRIGHT_KP:     pid_cfg.upright_kp     = val[KP_W-1:0];
            CFG_UPRIGHT_KD:     pid_cfg.upright_kd     = val[KD_W-1:0];
            CFG_SPEED_KP:       pid_cfg.speed_kp       = val[SKP_W-1:0];
            CFG_SPEED_KI:       pid_cfg.speed_ki       = val[SKI_W-1:0];
            CFG_INTEGRAL_LIMIT: pid_cfg.integral_limit = val[ILIM_W-1:0];
            CFG_DRIVE_LIMIT:    pid_cfg.drive_limit    = val[LIM_W-1:0];
            default:            pid_cfg.turn_offset    = val[TURN_W-1:0];
        endcase
        settings_used++;
    endtask

    task automatic write_all(cfg_t c);
        write_reg(CFG_TARGET_ANGLE,   CFG_DATA_W'(c.target_angle));
        write_reg(CFG_UPRIGHT_KP,     CFG_DATA_W'(c.upright_kp));
        write_reg(CFG_UPRIGHT_KD,     CFG_DATA_W'(c.upright_kd));
        write_reg(CFG_SPEED_KP,       CFG_DATA_W'(c.speed_kp));
        write_reg(CFG_SPEED_KI,       CFG_DATA_W'(c.speed_ki));
        write_reg(CFG_INTEGRAL_LIMIT, CFG_DATA_W'(c.integral_limit));
        write_reg(CFG_DRIVE_LIMIT,    CFG_DATA_W'(c.drive_limit));
        write_reg(CFG_TURN_OFFSET,    {2'b00, c.turn_offset});
    endtask

    task automatic load_tick(logic [ADC_BITS-1:0] angle, logic [ENC_W-1:0] enc, logic run,
                             logic [KEY_W-1:0] key);
        tick_q.push_back({angle, enc, run, key});
        ticks_loaded++;
    endtask

    task automatic load_random(int n);
        for (int i = 0; i < n; i++)
        begin
            tick_q.push_back(rand_tick());
            ticks_loaded++;
        end
    endtask

    // hold the sender until every loaded tick has been accepted and has produced its result
    task automatic drain();
        do
            @(posedge clk);
        while (ticks_taken != ticks_loaded || drive_exp_q.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                drive_exp_q.push_back(predict_drive(cur_tick));
                ticks_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur_tick = tick_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({cur_tick.enc, cur_tick.angle});
                    s_axis_tuser  <= {cur_tick.key, cur_tick.run};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (drive_exp_q.size() == 0)
                begin
                    $error("result beat with no tick outstanding");
                    errors++;
                end
                else
                begin
                    want = drive_exp_q.pop_front();
                    check_field("drive_forward", int'(want.fw),
                                int'(m_axis_tdata[DRIVE_BITS-1:0]));
                    check_field("drive_reverse", int'(want.rv),
                                int'(m_axis_tdata[2*DRIVE_BITS-1:DRIVE_BITS]));
                    check_field("balancing", int'(want.bal), int'(m_axis_tuser));
                    results_seen++;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $error("timeout: %0d of %0d ticks answered", results_seen, ticks_loaded);
        $display("pendulum_cascade_pid_test: errors");
        $finish;
    end

    initial
    begin
        cfg_t c;
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_pct = 26;
        errors = 0;
        ticks_loaded = 0;
        ticks_taken = 0;
        results_seen = 0;
        balance_ticks = 0;
        saturated_ticks = 0;
        settings_used = 1;
        pid_cfg = CFG_RESET;
        pid_prev_err = 0;
        pid_filt = 0;
        pid_integ = 0;
        pid_swing = '0;
        pid_held_fw = '0;
        pid_held_rv = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset gains
        load_tick(12'd1050, 16'h0000, 1'b1, KEY_BAL_LO);     // zero sum
        load_tick(12'd1000, 16'h0000, 1'b0, KEY_BAL_LO);     // not running
        load_tick(12'd401,  16'hFFFF, 1'b1, KEY_BAL_MID);    // window low edge, inside
        load_tick(12'd1699, 16'h0001, 1'b1, KEY_BAL_LO);     // window high edge, inside
        load_tick(12'd400,  16'h8000, 1'b1, KEY_BAL_LO);     // just outside, drives zero
        load_tick(12'd1700, 16'h7FFF, 1'b1, KEY_SWING_OUT);  // outside, swings
        load_tick(12'd0,    16'h0000, 1'b1, KEY_SWING_OUT);
        load_tick(12'hFFF,  16'hFFFF, 1'b1, KEY_TURN);
        load_tick(12'd900,  16'h0010, 1'b1, KEY_TURN);
        load_tick(12'd1200, 16'hFFF0, 1'b1, KEY_BAL_MID);
        load_tick(12'd1050, 16'h0000, 1'b1, KEY_HOLD0);
        load_tick(12'd1050, 16'h0000, 1'b1, KEY_HOLD2);
        load_tick(12'd1050, 16'h0000, 1'b1, KEY_HOLD7);
        load_tick(12'd1050, 16'h0000, 1'b1, KEY_SWING);
        load_tick(12'd3000, 16'h1234, 1'b1, KEY_SWING);
        load_tick(12'd200,  16'hABCD, 1'b1, KEY_SWING);
        load_tick(12'd1050, 16'h0000, 1'b1, KEY_HOLD7);
        load_tick(12'hFFF,  16'hFFFF, 1'b0, KEY_HOLD7);
        load_tick(12'd1050, 16'h0000, 1'b1, KEY_HOLD2);
        load_tick(12'd800,  16'h0100, 1'b1, KEY_BAL_LO);
        load_random(250);
        drain();

        write_all(rand_cfg());
        load_random(250);
        drain();

        // largest gains and limits; sum overflows upward with the turn offset
        c = '{target_angle: 12'd1050, upright_kp: 8'd255, upright_kd: 8'd255,
              speed_kp: 10'd1023, speed_ki: 8'd255, integral_limit: 15'd32767,
              drive_limit: 13'd7200, turn_offset: 13'sd4095};
        write_all(c);
        load_tick(12'd401,  16'h8000, 1'b1, KEY_TURN);
        load_tick(12'd401,  16'h8000, 1'b1, KEY_TURN);
        load_tick(12'd1699, 16'h7FFF, 1'b1, KEY_BAL_LO);
        load_random(200);
        drain();
        write_reg(CFG_TURN_OFFSET, {2'b00, 13'h1000});
        load_tick(12'd1699, 16'h7FFF, 1'b1, KEY_TURN);
        load_tick(12'd1699, 16'h7FFF, 1'b1, KEY_TURN);
        // long swing run wraps the swing phase
        for (int i = 0; i < 130; i++)
        begin
            load_tick(ADC_BITS'($urandom), ENC_W'($urandom), 1'b1, KEY_SWING);
        end
        drain();

        // smallest settings
        c = '{target_angle: 12'd0, upright_kp: 8'd0, upright_kd: 8'd0, speed_kp: 10'd0,
              speed_ki: 8'd0, integral_limit: 15'd0, drive_limit: 13'd0, turn_offset: 13'sd0};
        write_all(c);
        load_random(150);
        drain();

        write_all(rand_cfg());
        idle_pct = 0;
        load_random(300);
        drain();
        idle_pct = 26;

        c = rand_cfg();
        c.target_angle = 12'hFFF;
        write_all(c);
        load_random(250);
        drain();

        repeat (100) @(posedge clk);
        $display("ran %0d ticks over %0d register settings: %0d balancing, %0d saturated",
                 results_seen, settings_used, balance_ticks, saturated_ticks);
        if (drive_exp_q.size() != 0)
        begin
            $error("%0d results never arrived", drive_exp_q.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("pendulum_cascade_pid_test: clean");
        end
        else
        begin
            $display("pendulum_cascade_pid_test: errors");
        end
        $finish;
    end

endmodule
